FILE: rtl/core/cdu_pkg.sv
// ----------------------------------------------------------------------------
// cdu_pkg
// shared types and constants of the cosine distance unit
// ----------------------------------------------------------------------------
package cdu_pkg;

   localparam int DOT_W  = 42;
   localparam int NORM_W = 41;
   localparam int ROOT_W = 42;
   localparam int DIST_W = 18;
   localparam logic [DIST_W-1:0] ONE_Q16 = 18'd65536;

   // one finished vector handed from the front to the back
   typedef struct packed {
      logic [DOT_W-1:0]  dot;
      logic [NORM_W-1:0] norm_a;
      logic [NORM_W-1:0] norm_b;
      logic              ovf;
   } sums_type;

endpackage

FILE: rtl/core/cdu_front.sv
// ----------------------------------------------------------------------------
// cdu_front
// accumulates dot product and norms, hands finished sums to a 2-entry queue
// ----------------------------------------------------------------------------
module cdu_front import cdu_pkg::*; #(
   parameter int MAX_LEN      = 1024,
   parameter int ELEMENT_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [ELEMENT_BITS-1:0] in_a,
   input  logic [ELEMENT_BITS-1:0] in_b,
   input  logic                    in_last,
   output logic                    q_valid,
   input  logic                    q_ready,
   output sums_type                q_data
);
   localparam int CNT_W = $clog2(MAX_LEN + 1);

   logic [DOT_W-1:0]  dot_ff, dot_in;
   logic [NORM_W-1:0] na_ff, na_in, nb_ff, nb_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;
   sums_type          qmem_ff [2];
   logic              wp_ff, rp_ff;
   logic [1:0]        qcnt_ff;
   logic              push, pop;
   logic signed [2*ELEMENT_BITS-1:0] pab, paa, pbb;
   sums_type          done;

   assign in_ready = (qcnt_ff != 2'd2);
   assign push     = in_valid && in_ready && in_last;
   assign pop      = q_valid && q_ready;
   assign q_valid  = (qcnt_ff != 2'd0);
   assign q_data   = qmem_ff[rp_ff];

   // element products
   always_comb begin
      pab = $signed(in_a) * $signed(in_b);
      paa = $signed(in_a) * $signed(in_a);
      pbb = $signed(in_b) * $signed(in_b);
   end

   // running sums, drop pairs beyond the length limit
   always_comb begin
      dot_in = dot_ff;
      na_in  = na_ff;
      nb_in  = nb_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (cnt_ff < CNT_W'(MAX_LEN)) begin
         dot_in = dot_ff + DOT_W'($signed(pab));
         na_in  = na_ff + NORM_W'($unsigned(paa));
         nb_in  = nb_ff + NORM_W'($unsigned(pbb));
         cnt_in = cnt_ff + 1'b1;
      end else begin
         ovf_in = 1'b1;
      end
      done = '{dot: dot_in, norm_a: na_in, norm_b: nb_in, ovf: ovf_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ff  <= '0;
         na_ff   <= '0;
         nb_ff   <= '0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         qcnt_ff <= '0;
      end else begin
         if (in_valid && in_ready) begin
            if (in_last) begin
               dot_ff <= '0;
               na_ff  <= '0;
               nb_ff  <= '0;
               cnt_ff <= '0;
               ovf_ff <= 1'b0;
            end else begin
               dot_ff <= dot_in;
               na_ff  <= na_in;
               nb_ff  <= nb_in;
               cnt_ff <= cnt_in;
               ovf_ff <= ovf_in;
            end
         end
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         qcnt_ff <= qcnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) qmem_ff[wp_ff] <= done;
   end
endmodule

FILE: rtl/core/cdu_back.sv
// ----------------------------------------------------------------------------
// cdu_back
// product of norms, bitwise square root, restoring division, clamp
// ----------------------------------------------------------------------------
module cdu_back import cdu_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_ready,
   input  sums_type          q_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DIST_W-1:0] out_dist,
   output logic              out_zero,
   output logic              out_ovf
);
   typedef enum logic [5:0] {
      S_IDLE = 6'b000001, S_MUL = 6'b000010, S_SQRT = 6'b000100,
      S_DIV  = 6'b001000, S_FIN = 6'b010000, S_OUT  = 6'b100000
   } state_type;

   localparam int PROD_W = 2 * NORM_W;
   localparam int SQ_W   = 2 * ROOT_W;
   localparam int NUM_W  = DOT_W + 16;

   state_type          st_ff, st_in;
   sums_type           s_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [5:0]         step_ff;
   logic [1:0]         part_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]   quo_ff;
   logic [ROOT_W:0]    rem_ff;
   logic               neg_ff;
   logic [DIST_W-1:0]  dist_ff;
   logic               zero_ff;
   logic [ROOT_W-1:0]  trial;
   logic [SQ_W-1:0]    trial_sq;
   logic [ROOT_W:0]    rem_sh;
   logic [20:0]        a_part;
   logic [20:0]        b_part;
   logic [41:0]        pp;
   logic [DOT_W-1:0]   mag;

   assign q_ready   = (st_ff == S_IDLE);
   assign out_valid = (st_ff == S_OUT);
   assign out_dist  = dist_ff;
   assign out_zero  = zero_ff;
   assign out_ovf   = s_ff.ovf;

   // trial square without a multiplier: (r+2^k)^2 = r^2 + r*2^(k+1) + 2^(2k)
   always_comb begin
      trial    = root_ff | (ROOT_W'(1) << step_ff);
      trial_sq = sq_ff + (SQ_W'(root_ff) << (step_ff + 6'd1))
                 + (SQ_W'(1) << {step_ff, 1'b0});
      rem_sh   = {rem_ff[ROOT_W-1:0], num_ff[NUM_W-1]};
      a_part   = part_ff[0] ? {1'b0, s_ff.norm_a[NORM_W-1:21]} : s_ff.norm_a[20:0];
      b_part   = part_ff[1] ? {1'b0, s_ff.norm_b[NORM_W-1:21]} : s_ff.norm_b[20:0];
      pp       = a_part * b_part;
      mag      = s_ff.dot[DOT_W-1] ? (~s_ff.dot + 1'b1) : s_ff.dot;
   end

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: if (q_valid) st_in = S_MUL;
         S_MUL:  if (part_ff == 2'd3) st_in = S_SQRT;
         S_SQRT: if (step_ff == 6'd0) st_in = S_DIV;
         S_DIV:  if (step_ff == 6'd0) st_in = S_FIN;
         S_FIN:  st_in = S_OUT;
         S_OUT:  if (out_ready) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= S_IDLE;
      else       st_ff <= st_in;
   end

   // datapath: 4 partial products, 42 root steps, 58 divide steps
   always_ff @(posedge clock) begin
      unique case (st_ff)
         S_IDLE: begin
            s_ff    <= q_data;
            prod_ff <= '0;
            part_ff <= '0;
         end
         S_MUL: begin
            prod_ff <= prod_ff
                       + (PROD_W'(pp) << (21 * (32'(part_ff[0]) + 32'(part_ff[1]))));
            part_ff <= part_ff + 1'b1;
            root_ff <= '0;
            sq_ff   <= '0;
            step_ff <= 6'(ROOT_W - 1);
         end
         S_SQRT: begin
            if (trial_sq <= SQ_W'(prod_ff)) begin
               root_ff <= trial;
               sq_ff   <= trial_sq;
            end
            if (step_ff == 6'd0) begin
               step_ff <= 6'(NUM_W - 1);
               num_ff  <= {mag, 16'd0};
               neg_ff  <= s_ff.dot[DOT_W-1];
               rem_ff  <= '0;
               quo_ff  <= '0;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
         S_DIV: begin
            num_ff <= num_ff << 1;
            if (rem_sh >= {1'b0, root_ff}) begin
               rem_ff <= rem_sh - {1'b0, root_ff};
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
            end
            if (step_ff != 6'd0) step_ff <= step_ff - 1'b1;
         end
         S_FIN: begin
            zero_ff <= 1'b0;
            if (s_ff.norm_a == '0 || s_ff.norm_b == '0) begin
               dist_ff <= ONE_Q16;
               zero_ff <= 1'b1;
            end else if (root_ff == '0 || quo_ff > NUM_W'(ONE_Q16)) begin
               dist_ff <= neg_ff ? (ONE_Q16 << 1) : '0;
            end else begin
               dist_ff <= neg_ff ? ONE_Q16 + quo_ff[DIST_W-1:0]
                                 : ONE_Q16 - quo_ff[DIST_W-1:0];
            end
         end
         S_OUT: ;
         default: ;
      endcase
   end
endmodule

FILE: rtl/core/cosine_distance_unit.sv
// ----------------------------------------------------------------------------
// cosine_distance_unit
// streaming cosine distance of two signed integer vectors
// ----------------------------------------------------------------------------
// req_ beats carry one element pair each; req_tlast marks the final pair.
// the front adds one pair per cycle to dot and norms while req_tready is high.
// on tlast the sums go into a two-entry queue and the accumulators clear, so
// the next vector streams in while the back computes.
// the back works through one vector at a time: an idle state, 4 partial
// products of the norm product, 42 square-root steps, 58 restoring-divide
// steps, clamp, output.
// one rsp_ beat follows each tlast beat; no beat for other pairs.
// a stalled rsp_ holds the back, then the queue fills and req_tready drops.
// pairs beyond MAX_LEN are dropped and flagged in the result.
// reset clears sums, queue and the back state machine at once.
// ----------------------------------------------------------------------------
module cosine_distance_unit import cdu_pkg::*; #(
   parameter int MAX_LEN      = 1024,
   parameter int ELEMENT_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [2*ELEMENT_BITS-1:0] req_tdata,  // element_a, element_b
   input  logic                      req_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [23:0]               rsp_tdata,  // distance, zero_vector, length_overflow, pad
   output logic                      rsp_tlast
);
   logic              q_valid, q_ready;
   sums_type          q_data;
   logic [DIST_W-1:0] dist_value;
   logic              zero, ovf;

   cdu_front #(.MAX_LEN(MAX_LEN), .ELEMENT_BITS(ELEMENT_BITS)) u_front (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready),
      .in_a(req_tdata[ELEMENT_BITS-1:0]),
      .in_b(req_tdata[2*ELEMENT_BITS-1:ELEMENT_BITS]),
      .in_last(req_tlast),
      .q_valid, .q_ready, .q_data
   );

   cdu_back u_back (
      .clock, .reset, .q_valid, .q_ready, .q_data,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_dist(dist_value), .out_zero(zero), .out_ovf(ovf)
   );

   assign rsp_tdata = {4'd0, ovf, zero, dist_value};
   assign rsp_tlast = 1'b1;

   // checks
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:0] <= 18'd131072) else $error("distance range");
   a_zero_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18] |-> rsp_tdata[17:0] == 18'd65536) else $error("zero dist");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp hold");
endmodule

FILE: test/cosine_distance_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cosine_distance_unit_test
// self-checking bench for the streaming cosine distance unit
// ----------------------------------------------------------------------------
// element pairs stream in as vectors of short length, with a few
// extreme, parallel, opposite and zero vectors.
// a scoreboard keeps its own copy of the sums and predicts each distance,
// then compares every rsp_ beat with the oldest prediction.
// ----------------------------------------------------------------------------
module cosine_distance_unit_test;
   import cdu_pkg::*;

   localparam int MAX_LEN = 1024;

   typedef struct {
      logic [DIST_W-1:0] distance;
      logic              zero_vector;
      logic              length_overflow;
   } distance_type;

   // predicts distances from accepted pairs and checks rsp_ beats
   class distance_scoreboard;
      logic signed [DOT_W-1:0] dot;
      logic [NORM_W-1:0]       norm_a;
      logic [NORM_W-1:0]       norm_b;
      int                      count;
      bit                      ovf;
      distance_type            pending[$];
      int                      errors;

      function void clear_sums();
         dot = '0;
         norm_a = '0;
         norm_b = '0;
         count = 0;
         ovf = 0;
      endfunction

      function logic [ROOT_W-1:0] root_of_product(logic [NORM_W-1:0] x, logic [NORM_W-1:0] y);
         logic [83:0]       prod;
         logic [83:0]       sq;
         logic [ROOT_W-1:0] r;
         logic [ROOT_W-1:0] t;
         prod = 84'(x) * 84'(y);
         r = '0;
         for (int i = ROOT_W - 1; i >= 0; i--) begin
            t = r | (ROOT_W'(1) << i);
            sq = 84'(t) * 84'(t);
            if (sq <= prod) r = t;
         end
         return r;
      endfunction

      function void note_pair(logic signed [15:0] a, logic signed [15:0] b, bit last);
         longint       pab;
         longint       paa;
         longint       pbb;
         distance_type d;
         logic [DOT_W-1:0] mag;
         logic [63:0]  q;
         logic [ROOT_W-1:0] den;
         pab = longint'(a) * longint'(b);
         paa = longint'(a) * longint'(a);
         pbb = longint'(b) * longint'(b);
         if (count < MAX_LEN) begin
            dot = dot + pab[DOT_W-1:0];
            norm_a = norm_a + paa[NORM_W-1:0];
            norm_b = norm_b + pbb[NORM_W-1:0];
            count++;
         end else begin
            ovf = 1;
         end
         if (!last) return;
         if (norm_a == 0 || norm_b == 0) begin
            d.distance = ONE_Q16;
            d.zero_vector = 1;
         end else begin
            den = root_of_product(norm_a, norm_b);
            mag = dot[DOT_W-1] ? -dot : dot;
            q = (den != 0) ? ({6'b0, mag, 16'b0} / 64'(den)) : 64'(ONE_Q16);
            if (q > 64'(ONE_Q16)) q = 64'(ONE_Q16);
            d.distance = dot[DOT_W-1] ? ONE_Q16 + q[DIST_W-1:0] : ONE_Q16 - q[DIST_W-1:0];
            d.zero_vector = 0;
         end
         d.length_overflow = ovf;
         pending.push_back(d);
         clear_sums();
      endfunction

      function void check_result(logic [23:0] data);
         distance_type d;
         if (pending.size() == 0) begin
            $error("unexpected result beat %h", data);
            errors++;
            return;
         end
         d = pending.pop_front();
         if (data[17:0] !== d.distance) begin
            $error("distance: expected %0d actual %0d", d.distance, data[17:0]);
            errors++;
         end
         if (data[18] !== d.zero_vector) begin
            $error("zero_vector: expected %0d actual %0d", d.zero_vector, data[18]);
            errors++;
         end
         if (data[19] !== d.length_overflow) begin
            $error("length_overflow: expected %0d actual %0d", d.length_overflow, data[19]);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // element_a, element_b
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // distance, zero_vector, length_overflow, pad
   logic        rsp_tlast;

   distance_scoreboard board;
   bit                 idle_free;

   cosine_distance_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("cosine_distance_unit: mismatch");
      $finish;
   end

   function logic [15:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'h0001;
      endcase
   endfunction

   // one beat on req_, with an optional gap before it
   task send_pair(logic [15:0] a, logic [15:0] b, bit last);
      int gap;
      gap = idle_free ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {b, a};
      req_tlast <= last;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      board.note_pair(a, b, last);
      @(negedge clock);
   endtask

   // one vector: 0 random, 1 small, 2 parallel, 3 opposite, 4 extremes, 5 zero a
   task send_vector(int len, int mode);
      logic [15:0] a;
      logic [15:0] b;
      for (int i = 0; i < len; i++) begin
         a = $urandom;
         b = $urandom;
         case (mode)
            1: begin
               a = 16'($signed($urandom_range(0, 8)) - 4);
               b = 16'($signed($urandom_range(0, 8)) - 4);
            end
            2: b = a;
            3: b = -a;
            4: begin
               a = pick_extreme();
               b = pick_extreme();
            end
            5: a = 0;
            default: ;
         endcase
         send_pair(a, b, i == len - 1);
      end
   endtask

   // result side: optional random hold-off before each beat
   initial begin
      int w;
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         w = idle_free ? 0 : $urandom_range(0, 3);
         if (w > 0) begin
            rsp_tready = 0;
            repeat (w) @(negedge clock);
         end
         rsp_tready = 1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tdata);
         @(negedge clock);
      end
   end

   // stimulus
   initial begin
      int spent;
      board = new();
      board.clear_sums();
      board.errors = 0;
      idle_free = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tlast = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed vectors
      send_pair(16'h8000, 16'h8000, 1);
      send_pair(16'h8000, 16'h7fff, 1);
      send_pair(16'h7fff, 16'h7fff, 1);
      send_pair(16'h0000, 16'h1234, 1);
      send_pair(16'h0005, 16'h0000, 1);
      send_pair(16'h0000, 16'h0000, 1);
      send_pair(16'h0001, 16'h0000, 0);
      send_pair(16'h0000, 16'h0001, 1);
      send_pair(16'hffff, 16'h0001, 1);
      send_vector(3, 2);
      send_vector(3, 3);
      send_vector(4, 4);
      send_vector(2, 0);

      // hold off until every result is out
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);

      // random vectors
      spent = 0;
      while (spent < 525) begin
         int len;
         int mode;
         idle_free = ($urandom_range(0, 7) == 0);
         len = $urandom_range(1, 8);
         mode = $urandom_range(0, 9);
         if (mode > 5) mode = 0;
         send_vector(len, mode);
         spent += len;
      end
      idle_free = 0;
      send_vector(3, 1);

      req_tvalid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("cosine_distance_unit: match");
      else
         $display("cosine_distance_unit: mismatch");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/cdu_pkg.sv
rtl/core/cdu_front.sv
rtl/core/cdu_back.sv
rtl/core/cosine_distance_unit.sv
test/cosine_distance_unit_test.sv
